// File: hw/rtl/htfoi_pkg.sv
// Shared constants, codes and controller/datapath interface types for the hash table.
package htfoi_pkg;

    localparam int TABLE_DEPTH = 1024;
    localparam int SLOT_W      = 10;
    localparam int KEY_W       = 64;

    localparam logic [63:0] MIX_MULT  = 64'hff51afd7ed558ccd;
    localparam int          MIX_SHIFT = 33;

    localparam logic OP_FIND_INSERT = 1'b0;
    localparam logic OP_CLEAR       = 1'b1;

    localparam logic [1:0] RES_CLEAR  = 2'd0;
    localparam logic [1:0] RES_FOUND  = 2'd1;
    localparam logic [1:0] RES_INSERT = 2'd2;
    localparam logic [1:0] RES_FULL   = 2'd3;

    typedef struct packed {
        logic       capture;
        logic       hash_start;
        logic       load_home;
        logic       probe_next;
        logic       sweep_step;
        logic       write_insert;
        logic       load_out;
        logic [1:0] out_kind;
    } cmd_t;

    typedef struct packed {
        logic hash_done;
        logic slot_valid;
        logic key_match;
        logic probe_last;
        logic sweep_last;
    } sts_t;

endpackage

// File: hw/rtl/htfoi_hash.sv
// Key mixer and home-slot reduction: shared 32x32 multiplier, folding and reciprocal modulo.
module htfoi_hash #(
    parameter int TABLE_DEPTH = htfoi_pkg::TABLE_DEPTH
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           start,
    input  logic [63:0]                    key,
    output logic                           done,
    output logic [$clog2(TABLE_DEPTH)-1:0] home
);

    localparam int AW = $clog2(TABLE_DEPTH);
    localparam bit POW2 = (TABLE_DEPTH & (TABLE_DEPTH - 1)) == 0;
    localparam logic [63:0] DEPTH_C = 64'(TABLE_DEPTH);
    localparam logic [63:0] FOLD_R  = (64'd1 << 32) % DEPTH_C;
    localparam logic [63:0] RECIP_M = (64'd1 << 32) / DEPTH_C;

    localparam logic [2:0] PH_IDLE = 3'd0;
    localparam logic [2:0] PH_MUL  = 3'd1;
    localparam logic [2:0] PH_FOLD = 3'd2;
    localparam logic [2:0] PH_RED  = 3'd3;
    localparam logic [2:0] PH_PRD  = 3'd4;
    localparam logic [2:0] PH_FIX  = 3'd5;

    localparam logic [1:0] MUL_LAST = 2'd3;

    logic [2:0]    phase_reg;
    logic [1:0]    cnt_reg;
    logic          done_reg;
    logic [63:0]   x_reg;
    logic [63:0]   prod_reg;
    logic [63:0]   acc_reg;
    logic [63:0]   y_reg;
    logic [31:0]   q_reg;
    logic [31:0]   qd_reg;
    logic [AW-1:0] home_reg;

    logic [31:0]   mul_a;
    logic [31:0]   mul_b;
    logic [63:0]   mul_p;
    logic [63:0]   fold;
    logic          y_wide;
    logic [63:0]   red_p;
    logic [63:0]   quo_p;
    logic [63:0]   prd_p;
    logic [31:0]   rem_raw;
    logic [31:0]   rem_sub;
    logic [AW-1:0] rem_fix;

    // cross terms only contribute their low halves to the 64-bit product
    always_comb begin
        case (cnt_reg)
            2'd0: begin
                mul_a = x_reg[31:0];
                mul_b = htfoi_pkg::MIX_MULT[31:0];
            end
            2'd1: begin
                mul_a = x_reg[63:32];
                mul_b = htfoi_pkg::MIX_MULT[31:0];
            end
            default: begin
                mul_a = x_reg[31:0];
                mul_b = htfoi_pkg::MIX_MULT[63:32];
            end
        endcase
        mul_p   = 64'(mul_a) * 64'(mul_b);
        fold    = acc_reg ^ (acc_reg >> htfoi_pkg::MIX_SHIFT);
        // y = hi * 2^32 + lo is congruent to lo + hi * (2^32 mod depth)
        y_wide  = y_reg[63:32] != '0;
        red_p   = 64'(y_reg[31:0]) + 64'(y_reg[63:32]) * 64'(FOLD_R[AW-1:0]);
        // quotient estimate is low by at most one
        quo_p   = 64'(y_reg[31:0]) * 64'(RECIP_M[31:0]);
        prd_p   = 64'(q_reg) * 64'(DEPTH_C[AW:0]);
        rem_raw = y_reg[31:0] - qd_reg;
        rem_sub = rem_raw - DEPTH_C[31:0];
        rem_fix = (rem_raw >= DEPTH_C[31:0]) ? rem_sub[AW-1:0] : rem_raw[AW-1:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_IDLE;
            cnt_reg   <= '0;
            done_reg  <= 1'b0;
        end else begin
            case (phase_reg)
                PH_IDLE: begin
                    done_reg <= 1'b0;
                    if (start) begin
                        phase_reg <= PH_MUL;
                        cnt_reg   <= '0;
                    end
                end
                PH_MUL: begin
                    done_reg <= 1'b0;
                    if (cnt_reg == MUL_LAST) begin
                        phase_reg <= PH_FOLD;
                    end
                    cnt_reg <= cnt_reg + 2'd1;
                end
                PH_FOLD: begin
                    if (POW2) begin
                        phase_reg <= PH_IDLE;
                        done_reg  <= 1'b1;
                    end else begin
                        phase_reg <= PH_RED;
                        done_reg  <= 1'b0;
                    end
                end
                PH_RED: begin
                    done_reg <= 1'b0;
                    if (!y_wide) begin
                        phase_reg <= PH_PRD;
                    end
                end
                PH_PRD: begin
                    done_reg  <= 1'b0;
                    phase_reg <= PH_FIX;
                end
                PH_FIX: begin
                    done_reg  <= 1'b1;
                    phase_reg <= PH_IDLE;
                end
                default: begin
                    done_reg  <= 1'b0;
                    phase_reg <= PH_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        case (phase_reg)
            PH_IDLE: begin
                if (start) begin
                    x_reg <= key ^ (key >> htfoi_pkg::MIX_SHIFT);
                end
            end
            PH_MUL: begin
                prod_reg <= mul_p;
                case (cnt_reg)
                    2'd1: begin
                        acc_reg <= prod_reg;
                    end
                    2'd2, 2'd3: begin
                        acc_reg[63:32] <= acc_reg[63:32] + prod_reg[31:0];
                    end
                    default: begin
                    end
                endcase
            end
            PH_FOLD: begin
                y_reg    <= fold;
                home_reg <= fold[AW-1:0];
            end
            PH_RED: begin
                if (y_wide) begin
                    y_reg <= red_p;
                end else begin
                    q_reg <= quo_p[63:32];
                end
            end
            PH_PRD: begin
                qd_reg <= prd_p[31:0];
            end
            PH_FIX: begin
                home_reg <= rem_fix;
            end
            default: begin
            end
        endcase
    end

    assign done = done_reg;
    assign home = home_reg;

endmodule

// File: hw/rtl/htfoi_dp.sv
// Datapath: slot memory, probe pointer and counter, clear sweep, result register.
module htfoi_dp #(
    parameter int TABLE_DEPTH = htfoi_pkg::TABLE_DEPTH
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic [htfoi_pkg::KEY_W-1:0]   in_key,
    input  htfoi_pkg::cmd_t               cmd,
    output htfoi_pkg::sts_t               sts,
    output logic [htfoi_pkg::SLOT_W-1:0]  slot_index,
    output logic                          found,
    output logic                          inserted,
    output logic                          table_full
);

    localparam int AW = $clog2(TABLE_DEPTH);
    localparam int KW = htfoi_pkg::KEY_W;
    localparam int SW = htfoi_pkg::SLOT_W;
    localparam logic [AW-1:0] LAST_SLOT = AW'(TABLE_DEPTH - 1);

    logic [KW:0]   mem [TABLE_DEPTH];
    logic [KW:0]   rdata_reg;
    logic [KW-1:0] key_reg;
    logic [AW-1:0] pos_reg;
    logic [AW-1:0] cnt_reg;
    logic [AW-1:0] sweep_reg;
    logic [SW-1:0] slot_reg;
    logic          found_reg;
    logic          inserted_reg;
    logic          full_reg;

    logic [AW-1:0]    home;
    logic             hash_done;
    logic [AW+SW-1:0] slot_ext;

    htfoi_hash #(
        .TABLE_DEPTH(TABLE_DEPTH)
    ) u_hash (
        .aclk   (aclk),
        .aresetn(aresetn),
        .start  (cmd.hash_start),
        .key    (in_key),
        .done   (hash_done),
        .home   (home)
    );

    always_ff @(posedge aclk) begin
        if (cmd.sweep_step) begin
            mem[sweep_reg] <= '0;
        end else if (cmd.write_insert) begin
            mem[pos_reg] <= {1'b1, key_reg};
        end
    end

    always_ff @(posedge aclk) begin
        rdata_reg <= mem[pos_reg];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sweep_reg <= '0;
        end else if (cmd.sweep_step) begin
            sweep_reg <= (sweep_reg == LAST_SLOT) ? '0 : sweep_reg + AW'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            key_reg <= in_key;
        end
        if (cmd.load_home) begin
            pos_reg <= home;
            cnt_reg <= '0;
        end else if (cmd.probe_next) begin
            pos_reg <= (pos_reg == LAST_SLOT) ? '0 : pos_reg + AW'(1);
            cnt_reg <= cnt_reg + AW'(1);
        end
    end

    assign slot_ext = {{SW{1'b0}}, pos_reg};

    always_ff @(posedge aclk) begin
        if (cmd.load_out) begin
            case (cmd.out_kind)
                htfoi_pkg::RES_FOUND: begin
                    slot_reg     <= slot_ext[SW-1:0];
                    found_reg    <= 1'b1;
                    inserted_reg <= 1'b0;
                    full_reg     <= 1'b0;
                end
                htfoi_pkg::RES_INSERT: begin
                    slot_reg     <= slot_ext[SW-1:0];
                    found_reg    <= 1'b0;
                    inserted_reg <= 1'b1;
                    full_reg     <= 1'b0;
                end
                htfoi_pkg::RES_FULL: begin
                    slot_reg     <= '0;
                    found_reg    <= 1'b0;
                    inserted_reg <= 1'b0;
                    full_reg     <= 1'b1;
                end
                default: begin
                    slot_reg     <= '0;
                    found_reg    <= 1'b0;
                    inserted_reg <= 1'b0;
                    full_reg     <= 1'b0;
                end
            endcase
        end
    end

    assign sts.hash_done  = hash_done;
    assign sts.slot_valid = rdata_reg[KW];
    assign sts.key_match  = rdata_reg[KW-1:0] == key_reg;
    assign sts.probe_last = cnt_reg == LAST_SLOT;
    assign sts.sweep_last = sweep_reg == LAST_SLOT;

    assign slot_index = slot_reg;
    assign found      = found_reg;
    assign inserted   = inserted_reg;
    assign table_full = full_reg;

endmodule

// File: hw/rtl/htfoi_ctrl.sv
// Controller state machine: request sequencing, probe decisions, result handshake.
module htfoi_ctrl (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            s_tvalid,
    output logic            s_tready,
    input  logic            in_op,
    input  logic            m_tready,
    output logic            m_tvalid,
    output htfoi_pkg::cmd_t cmd,
    input  htfoi_pkg::sts_t sts
);

    localparam logic [2:0] S_INIT     = 3'd0;
    localparam logic [2:0] S_IDLE     = 3'd1;
    localparam logic [2:0] S_HASH     = 3'd2;
    localparam logic [2:0] S_RD       = 3'd3;
    localparam logic [2:0] S_CHK      = 3'd4;
    localparam logic [2:0] S_CLR      = 3'd5;
    localparam logic [2:0] S_CLR_DONE = 3'd6;

    logic [2:0] state_reg;
    logic [2:0] state_next;
    logic       m_tvalid_reg;
    logic       out_free;
    logic       accept;

    assign s_tready = state_reg == S_IDLE;
    assign accept   = s_tvalid && s_tready;
    assign out_free = !m_tvalid_reg || m_tready;

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            S_INIT: begin
                cmd.sweep_step = 1'b1;
                if (sts.sweep_last) begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE: begin
                if (accept) begin
                    cmd.capture = 1'b1;
                    if (in_op == htfoi_pkg::OP_CLEAR) begin
                        state_next = S_CLR;
                    end else begin
                        cmd.hash_start = 1'b1;
                        state_next     = S_HASH;
                    end
                end
            end
            S_HASH: begin
                if (sts.hash_done) begin
                    cmd.load_home = 1'b1;
                    state_next    = S_RD;
                end
            end
            S_RD: begin
                state_next = S_CHK;
            end
            S_CHK: begin
                if (!sts.slot_valid) begin
                    cmd.out_kind = htfoi_pkg::RES_INSERT;
                    if (out_free) begin
                        cmd.write_insert = 1'b1;
                        cmd.load_out     = 1'b1;
                        state_next       = S_IDLE;
                    end
                end else if (sts.key_match) begin
                    cmd.out_kind = htfoi_pkg::RES_FOUND;
                    if (out_free) begin
                        cmd.load_out = 1'b1;
                        state_next   = S_IDLE;
                    end
                end else if (sts.probe_last) begin
                    cmd.out_kind = htfoi_pkg::RES_FULL;
                    if (out_free) begin
                        cmd.load_out = 1'b1;
                        state_next   = S_IDLE;
                    end
                end else begin
                    cmd.probe_next = 1'b1;
                    state_next     = S_RD;
                end
            end
            S_CLR: begin
                cmd.sweep_step = 1'b1;
                if (sts.sweep_last) begin
                    state_next = S_CLR_DONE;
                end
            end
            S_CLR_DONE: begin
                cmd.out_kind = htfoi_pkg::RES_CLEAR;
                if (out_free) begin
                    cmd.load_out = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_INIT;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_INIT;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (cmd.load_out) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    assign m_tvalid = m_tvalid_reg;

endmodule

// File: hw/rtl/hash_table_find_or_insert.sv
// Top level of the linear-probing find-or-insert hash table of 64-bit keys.
//
// Requests enter on the s_ stream: s_tdata carries the key, s_tuser the
// operation (find-or-insert or clear table). Every request yields exactly one
// result on the m_ stream: m_tdata carries the slot index, m_tuser the flags
// found, inserted and table_full.
// The key mixer shares one 32x32 multiplier over its three partial products,
// a non-power-of-two depth adds the folding steps that bring the mixed key
// under 32 bits, a reciprocal multiply, a back multiply and a correction, and
// each probe reads the slot memory through its registered read port. A clear
// request sweeps the memory one slot per cycle and then returns its result.
// After reset the same sweep runs with s_tready low.
// One request is in work at a time; s_tready returns high when its result is
// loaded into the output register, so the next request is taken while that
// result still waits. If the receiver stalls, the result holds and a further
// request completes all of its probing before it waits for the output.
module hash_table_find_or_insert #(
    parameter int TABLE_DEPTH = htfoi_pkg::TABLE_DEPTH
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,   // key[63:0]
    input  logic [0:0]  s_tuser,   // operation[0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // slot_index[9:0], zero[15:10]
    output logic [2:0]  m_tuser    // found[0], inserted[1], table_full[2]
);

    htfoi_pkg::cmd_t                  cmd;
    htfoi_pkg::sts_t                  sts;
    logic [htfoi_pkg::SLOT_W-1:0]     slot_index;
    logic                             found;
    logic                             inserted;
    logic                             table_full;

    htfoi_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .in_op   (s_tuser[0]),
        .m_tready(m_tready),
        .m_tvalid(m_tvalid),
        .cmd     (cmd),
        .sts     (sts)
    );

    htfoi_dp #(
        .TABLE_DEPTH(TABLE_DEPTH)
    ) u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_key    (s_tdata),
        .cmd       (cmd),
        .sts       (sts),
        .slot_index(slot_index),
        .found     (found),
        .inserted  (inserted),
        .table_full(table_full)
    );

    assign m_tdata = {{(16 - htfoi_pkg::SLOT_W){1'b0}}, slot_index};
    assign m_tuser = {table_full, inserted, found};

endmodule
